FILE: hdl/lfrg_pkg.sv
// ----------------------------------------------------------------------------
// lfrg_pkg
// Shared types and constants of the LED frame generator.
// ----------------------------------------------------------------------------
package lfrg_pkg;

    localparam int unsigned LED_COUNT_DEF = 3;

    localparam logic [7:0] START_BYTE = 8'h00;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [7:0] LEVEL_MARK = 8'hE0;
    localparam logic [7:0] FULL_LEVEL = 8'hFF;
    localparam logic [7:0] ZERO_LEVEL = 8'h00;

    localparam int unsigned START_LEN = 4;
    localparam int unsigned END_LEN   = 4;
    localparam int unsigned LED_LEN   = 4;

    // request codes
    localparam logic REQ_RAINBOW = 1'b0;
    localparam logic REQ_FIXED   = 1'b1;

    // byte slot inside one LED record
    localparam logic [1:0] SLOT_LEVEL = 2'd0;
    localparam logic [1:0] SLOT_BLUE  = 2'd1;
    localparam logic [1:0] SLOT_GREEN = 2'd2;
    localparam logic [1:0] SLOT_RED   = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    // color wheel phases
    typedef enum logic [5:0] {
        PH_GREEN_UP = 6'b000001,
        PH_RED_DN   = 6'b000010,
        PH_BLUE_UP  = 6'b000100,
        PH_GREEN_DN = 6'b001000,
        PH_RED_UP   = 6'b010000,
        PH_BLUE_DN  = 6'b100000
    } t_phase;

endpackage

FILE: hdl/lfrg_req_if.sv
// ----------------------------------------------------------------------------
// lfrg_req_if
// Request channel: frame request with brightness and fixed color.
// ----------------------------------------------------------------------------
interface lfrg_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [4:0] level;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, req_type, level, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, req_type, level, red_in, green_in, blue_in,
                    output ready);
endinterface

FILE: hdl/lfrg_byte_if.sv
// ----------------------------------------------------------------------------
// lfrg_byte_if
// Byte channel: one frame byte per transaction, last flag on the final byte.
// ----------------------------------------------------------------------------
interface lfrg_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

FILE: hdl/lfrg_wheel.sv
// ----------------------------------------------------------------------------
// lfrg_wheel
// Six-phase rainbow color wheel; steps one count per advance strobe.
// ----------------------------------------------------------------------------
module lfrg_wheel
    import lfrg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    output t_color o_next
);

    t_color r_color, n_color;
    t_phase r_phase, n_phase;

    always_comb begin
        n_color = r_color;
        n_phase = r_phase;
        case (r_phase)
            PH_GREEN_UP: begin
                n_color.green = r_color.green + 8'd1;
                if (n_color.green == FULL_LEVEL) n_phase = PH_RED_DN;
            end
            PH_RED_DN: begin
                n_color.red = r_color.red - 8'd1;
                if (n_color.red == ZERO_LEVEL) n_phase = PH_BLUE_UP;
            end
            PH_BLUE_UP: begin
                n_color.blue = r_color.blue + 8'd1;
                if (n_color.blue == FULL_LEVEL) n_phase = PH_GREEN_DN;
            end
            PH_GREEN_DN: begin
                n_color.green = r_color.green - 8'd1;
                if (n_color.green == ZERO_LEVEL) n_phase = PH_RED_UP;
            end
            PH_RED_UP: begin
                n_color.red = r_color.red + 8'd1;
                if (n_color.red == FULL_LEVEL) n_phase = PH_BLUE_DN;
            end
            PH_BLUE_DN: begin
                n_color.blue = r_color.blue - 8'd1;
                if (n_color.blue == ZERO_LEVEL) n_phase = PH_GREEN_UP;
            end
            default: begin
                n_phase = PH_GREEN_UP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '{red: FULL_LEVEL, green: ZERO_LEVEL, blue: ZERO_LEVEL};
            r_phase <= PH_GREEN_UP;
        end else if (i_adv) begin
            r_color <= n_color;
            r_phase <= n_phase;
        end
    end

    assign o_next = n_color;

endmodule

FILE: hdl/led_frame_rainbow_gen.sv
// ----------------------------------------------------------------------------
// led_frame_rainbow_gen
// APA102-style LED frame generator with a rainbow color wheel.
//
// i_req (sink): one transaction per frame. req_type 0 steps the color wheel
//   and sends its new color, req_type 1 sends red_in/green_in/blue_in.
// o_byte (source): the frame, one byte per transaction: four 0x00, then per
//   LED (level | 0xE0), blue, green, red, then four 0xFF; last_byte marks
//   the final 0xFF.
// A request waits in the request buffer, is loaded into the frame registers,
//   and its bytes leave through the output register. A frame is
//   8 + 4*NUM_LEDS bytes (20 at three LEDs), serialized by the byte counter
//   at one byte per cycle while o_byte is not stalled. One request is
//   buffered while a frame streams, so frames follow back to back.
// Reset: clears the buffer and output valid; the wheel returns to red.
// Stall: while a byte waits and o_byte.ready is low, the byte register holds
//   and the counter waits; i_req.ready is low while a full buffer is not loading.
// ----------------------------------------------------------------------------
module led_frame_rainbow_gen
    import lfrg_pkg::*;
#(
    parameter int unsigned NUM_LEDS = LED_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lfrg_req_if.sink     i_req,
    lfrg_byte_if.source  o_byte
);

    localparam int unsigned FRAME_LEN = START_LEN + LED_LEN * NUM_LEDS + END_LEN;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_LED_BEG = CNT_W'(START_LEN);
    localparam logic [CNT_W-1:0] CNT_END_BEG = CNT_W'(START_LEN + LED_LEN * NUM_LEDS);

    // request buffer
    logic       r_in_vld;
    logic [4:0] r_in_lvl;
    t_color     r_in_color;

    // frame under way
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [4:0]       r_lvl;
    t_color           r_color;

    // output register
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    t_color     w_wheel;
    logic       w_accept;
    logic       w_step;
    logic       w_at_end;
    logic       w_load;
    logic [7:0] n_byte;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_step   = r_busy && (!r_out_vld || o_byte.ready);
    assign w_at_end = (r_cnt == CNT_LAST);
    assign w_load   = r_in_vld && (!r_busy || (w_step && w_at_end));
    assign i_req.ready = !r_in_vld || w_load;

    lfrg_wheel u_wheel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_accept && (i_req.req_type == REQ_RAINBOW)),
        .o_next  (w_wheel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_lvl <= i_req.level;
            if (i_req.req_type == REQ_FIXED) begin
                r_in_color <= '{red: i_req.red_in, green: i_req.green_in,
                                blue: i_req.blue_in};
            end else begin
                r_in_color <= w_wheel;
            end
        end
    end

    // byte select; LED records start on a multiple of four, so cnt[1:0] is the slot
    always_comb begin
        if (r_cnt < CNT_LED_BEG) begin
            n_byte = START_BYTE;
        end else if (r_cnt >= CNT_END_BEG) begin
            n_byte = END_BYTE;
        end else begin
            case (r_cnt[1:0])
                SLOT_LEVEL: n_byte = LEVEL_MARK | {3'b000, r_lvl};
                SLOT_BLUE:  n_byte = r_color.blue;
                SLOT_GREEN: n_byte = r_color.green;
                SLOT_RED:   n_byte = r_color.red;
                default:    n_byte = START_BYTE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_step) begin
            if (w_at_end) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_lvl   <= r_in_lvl;
            r_color <= r_in_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (o_byte.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_byte <= n_byte;
            r_out_last <= w_at_end;
        end
    end

    assign o_byte.valid     = r_out_vld;
    assign o_byte.out_byte  = r_out_byte;
    assign o_byte.last_byte = r_out_last;

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_last) |-> (r_out_byte == END_BYTE))
        else $error("last byte is not an end byte");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= CNT_LAST))
        else $error("byte counter out of frame");

    a_idle_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_busy) |=> (r_busy && (r_cnt == '0)))
        else $error("buffered request not started while idle");

    a_buf_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_busy && !(w_step && w_at_end)) |-> !i_req.ready)
        else $error("request taken while buffer full");

endmodule
